// ----- rtl/stq_pkg.sv -----
// Shared types and codes for the sorted timer expiry queue.
// Depends on nothing; used by stq_if and sorted_timer_expiry_queue_top (stq_mem does not use it).
`timescale 1ns / 1ps
package stq_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned FuncBits   = 2;
  localparam int unsigned IdPortBits = 8;
  localparam int unsigned TimeBits   = 32;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_DEL     = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ----- rtl/stq_if.sv -----
// Valid/ready channel interfaces for command words and result words.
// Depends on stq_pkg for the field widths.
`timescale 1ns / 1ps
interface stq_in_if;
  logic                            valid;
  logic                            ready;
  logic [stq_pkg::FuncBits-1:0]    func;
  logic [stq_pkg::IdPortBits-1:0]  timer_id;
  logic [stq_pkg::TimeBits-1:0]    expires;

  modport source (output valid, func, timer_id, expires, input ready);
  modport sink   (input valid, func, timer_id, expires, output ready);
endinterface

interface stq_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [stq_pkg::IdPortBits-1:0]  timer_id_res;
  logic [1:0]                      status;
  logic [stq_pkg::TimeBits-1:0]    now;
  logic                            last;

  modport source (output valid, kind, timer_id_res, status, now, last, input ready);
  modport sink   (input valid, kind, timer_id_res, status, now, last, output ready);
endinterface

// ----- rtl/stq_mem.sv -----
// Entry table storage: one write port, one read port, registered read data.
// Standalone; instantiated by sorted_timer_expiry_queue_top.
`timescale 1ns / 1ps
module stq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/sorted_timer_expiry_queue_top.sv -----
// Sorted timer queue: one command word at a time, entries in a circular table memory.
// Operation: add or delete scans the N queued entries, then shifts the S entries that move
//   (a read and a write for each); a tick reads and emits each expired entry, then emits
//   the done word. The sequential table walk, one access at a time, sets the rate.
// Throughput: one command word per completed command; results leave through a register.
// Reset: asynchronous; clears entry count, head pointer and tick count, table is not cleared.
`timescale 1ns / 1ps
module sorted_timer_expiry_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  stq_in_if.sink    in_i,
  stq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = stq_pkg::TimeBits;
  localparam int unsigned MW = ID_BITS + TW;
  localparam logic [AW:0]   DepthW = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_UP_RD, S_UP_WR, S_WR_NEW,
    S_DN_RD, S_DN_WR, S_T_RD, S_T_CHK, S_EMIT
  } state_e;

  state_e                state_q, ret_q;
  stq_pkg::func_e        func_q;
  logic [ID_BITS-1:0]    id_q;
  logic [TW-1:0]         exp_q;
  logic [TW-1:0]         now_q;
  logic [AW-1:0]         head_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         idx_q;
  logic [CW-1:0]         pos_q;
  logic                  pos_set_q;
  logic                  found_q;
  logic [CW-1:0]         fpos_q;
  stq_pkg::kind_e        res_kind_q;
  logic [ID_BITS-1:0]    res_id_q;
  stq_pkg::status_e      res_status_q;
  logic                  res_last_q;
  logic                  out_valid_q;
  stq_pkg::kind_e        out_kind_q;
  logic [ID_BITS-1:0]    out_id_q;
  stq_pkg::status_e      out_status_q;
  logic [TW-1:0]         out_now_q;
  logic                  out_last_q;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [MW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MW-1:0]         wr_data;
  logic [ID_BITS-1:0]    rd_id;
  logic [TW-1:0]         rd_exp;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         idx_p1;

  // Map a position in sorted order onto a table address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[AW-1:0];
  endfunction

  assign rd_id  = rd_data[MW-1:TW];
  assign rd_exp = rd_data[TW-1:0];
  assign idx_m1 = idx_q - 1'b1;
  assign idx_p1 = idx_q + 1'b1;

  // Table access per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    wr_data = {id_q, exp_q};
    unique case (state_q)
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_q, idx_q[AW-1:0]);
      end
      S_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_q, idx_m1[AW-1:0]);
      end
      S_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, idx_q[AW-1:0]);
        wr_data = rd_data;
      end
      S_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, pos_q[AW-1:0]);
      end
      S_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_q, idx_p1[AW-1:0]);
      end
      S_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, idx_q[AW-1:0]);
        wr_data = rd_data;
      end
      S_T_RD: begin
        rd_en   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  stq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(MW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      func_q       <= stq_pkg::FUNC_ADD;
      id_q         <= '0;
      exp_q        <= '0;
      now_q        <= '0;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      pos_set_q    <= 1'b0;
      found_q      <= 1'b0;
      fpos_q       <= '0;
      res_kind_q   <= stq_pkg::KIND_ADD;
      res_id_q     <= '0;
      res_status_q <= stq_pkg::ST_OK;
      res_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= stq_pkg::KIND_ADD;
      out_id_q     <= '0;
      out_status_q <= stq_pkg::ST_OK;
      out_now_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it
      if (out_valid_q && out_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            id_q      <= ID_BITS'(in_i.timer_id);
            exp_q     <= in_i.expires;
            idx_q     <= '0;
            pos_q     <= count_q;
            pos_set_q <= 1'b0;
            found_q   <= 1'b0;
            priority case (in_i.func)
              stq_pkg::FUNC_ADD, stq_pkg::FUNC_DEL: begin
                func_q  <= stq_pkg::func_e'(in_i.func);
                state_q <= (count_q != '0) ? S_SCAN_RD : S_DECIDE;
              end
              stq_pkg::FUNC_TICK: begin
                func_q  <= stq_pkg::FUNC_TICK;
                now_q   <= now_q + 1'b1;
                state_q <= S_T_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rd_id == id_q) begin
            found_q <= 1'b1;
            fpos_q  <= idx_q;
          end
          if (!pos_set_q && (rd_exp > exp_q)) begin
            pos_q     <= idx_q;
            pos_set_q <= 1'b1;
          end
          idx_q   <= idx_p1;
          state_q <= (idx_p1 == count_q) ? S_DECIDE : S_SCAN_RD;
        end
        S_DECIDE: begin
          res_id_q     <= id_q;
          res_last_q   <= 1'b1;
          res_status_q <= stq_pkg::ST_OK;
          ret_q        <= S_IDLE;
          if (func_q == stq_pkg::FUNC_ADD) begin
            res_kind_q <= stq_pkg::KIND_ADD;
            if (found_q) begin
              res_status_q <= stq_pkg::ST_DUPLICATE;
              state_q      <= S_EMIT;
            end else if (count_q == DepthC) begin
              res_status_q <= stq_pkg::ST_FULL;
              state_q      <= S_EMIT;
            end else begin
              idx_q   <= count_q;
              state_q <= (count_q > pos_q) ? S_UP_RD : S_WR_NEW;
            end
          end else begin
            res_kind_q <= stq_pkg::KIND_DEL;
            if (!found_q) begin
              res_status_q <= stq_pkg::ST_NOT_FOUND;
              state_q      <= S_EMIT;
            end else if ((fpos_q + 1'b1) < count_q) begin
              idx_q   <= fpos_q;
              state_q <= S_DN_RD;
            end else begin
              count_q <= count_q - 1'b1;
              state_q <= S_EMIT;
            end
          end
        end
        S_UP_RD: state_q <= S_UP_WR;
        S_UP_WR: begin
          idx_q   <= idx_m1;
          state_q <= (idx_m1 > pos_q) ? S_UP_RD : S_WR_NEW;
        end
        S_WR_NEW: begin
          count_q <= count_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_DN_RD: state_q <= S_DN_WR;
        S_DN_WR: begin
          idx_q <= idx_p1;
          if (((CW + 1)'(idx_q) + (CW + 1)'(2)) < (CW + 1)'(count_q)) begin
            state_q <= S_DN_RD;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_T_RD: begin
          if (count_q == '0) begin
            res_kind_q   <= stq_pkg::KIND_DONE;
            res_id_q     <= '0;
            res_status_q <= stq_pkg::ST_OK;
            res_last_q   <= 1'b1;
            ret_q        <= S_IDLE;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_T_CHK;
          end
        end
        S_T_CHK: begin
          res_status_q <= stq_pkg::ST_OK;
          state_q      <= S_EMIT;
          if (rd_exp <= now_q) begin
            // Pop the head entry
            head_q     <= phys(head_q, AW'(1));
            count_q    <= count_q - 1'b1;
            res_kind_q <= stq_pkg::KIND_EXPIRED;
            res_id_q   <= rd_id;
            res_last_q <= 1'b0;
            ret_q      <= S_T_RD;
          end else begin
            res_kind_q <= stq_pkg::KIND_DONE;
            res_id_q   <= '0;
            res_last_q <= 1'b1;
            ret_q      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= res_kind_q;
            out_id_q     <= res_id_q;
            out_status_q <= res_status_q;
            out_now_q    <= now_q;
            out_last_q   <= res_last_q;
            state_q      <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.timer_id_res = stq_pkg::IdPortBits'(out_id_q);
  assign out_o.status       = out_status_q;
  assign out_o.now          = out_now_q;
  assign out_o.last         = out_last_q;

  // Entry count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("entry count beyond table size");

  // Table is never written while waiting for a command
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en) else $error("table write while idle");

  // A pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T_CHK && rd_exp <= now_q) |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not remove one entry");

  // A tick done word always closes the command
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == stq_pkg::KIND_DONE) |-> out_last_q)
    else $error("tick done word without last");

endmodule
